// ===== rtl/pfa_pkg.sv =====
// Shared types, constants and ring arithmetic for the paged frame allocator.
package pfa_pkg;

   // Sizing
   localparam int FRAMES   = 64;
   localparam int MAX_JOBS = 16;

   localparam int FRAME_W  = $clog2(FRAMES);
   localparam int COUNT_W  = $clog2(FRAMES + 1);
   localparam int JOB_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int JF_AW    = JOB_W + FRAME_W;
   localparam int JF_DEPTH = 1 << JF_AW;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFRAMES = 2'd1,
      ST_UNKNOWN  = 2'd2,
      ST_BUSY     = 2'd3
   } status_type;

   // Request word
   typedef struct packed {
      opcode_type         opcode;
      logic [JOB_W-1:0]   job_id;
      logic [COUNT_W-1:0] request_size;
   } req_type;

   // Response word
   typedef struct packed {
      status_type         status;
      logic [FRAME_W-1:0] page_number;
      logic [FRAME_W-1:0] frame_number;
      logic [COUNT_W-1:0] free_frames;
      logic               last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       err;
      status_type err_code;
      logic       alloc_start;
      logic       free_start;
      logic       issue;
      logic       done_free;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic id_bad;
      logic live;
      logic size_zero;
      logic size_gt;
      logic op_free;
      logic k_last;
   } stat_type;

   // (a + b) mod FRAMES, for a < FRAMES and b <= FRAMES
   function automatic logic [FRAME_W-1:0] ring_add(input logic [FRAME_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
      logic [FRAME_W:0] sum;
      sum = (FRAME_W+1)'(a) + (FRAME_W+1)'(b);
      if (sum >= (FRAME_W+1)'(FRAMES)) begin
         sum = sum - (FRAME_W+1)'(FRAMES);
      end
      return sum[FRAME_W-1:0];
   endfunction

endpackage

// ===== rtl/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pfa_ctrl.sv =====
// Request sequencer: decides each request and steps the datapath through it.
module pfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pfa_pkg::stat_type stat,
   output pfa_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_RUN,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      cmd.err_code = pfa_pkg::ST_OK;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_IDLE;
            if (stat.id_bad) begin
               cmd.err      = 1'b1;
               cmd.err_code = pfa_pkg::ST_UNKNOWN;
            end else if (!stat.op_free) begin
               if (stat.live || stat.size_zero) begin
                  cmd.err      = 1'b1;
                  cmd.err_code = pfa_pkg::ST_BUSY;
               end else if (stat.size_gt) begin
                  cmd.err      = 1'b1;
                  cmd.err_code = pfa_pkg::ST_NOFRAMES;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in        = S_RUN;
               end
            end else if (!stat.live) begin
               cmd.err      = 1'b1;
               cmd.err_code = pfa_pkg::ST_UNKNOWN;
            end else begin
               cmd.free_start = 1'b1;
               state_in       = S_RUN;
            end
         end
         S_RUN: begin
            // one list or page-table entry per cycle
            cmd.issue = 1'b1;
            if (stat.k_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.done_free = stat.op_free;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

`ifndef NO_ASSERTIONS
   // busy mirrors the sequencer leaving idle
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) == !busy_ff)
      else $error("busy out of step with state");

   // a request is never taken while the sequencer works
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CHECK)
      else $error("load outside idle");
`endif

endmodule

// ===== rtl/pfa_dp.sv =====
// Datapath: free-frame ring, page table, job bookkeeping and response register.
module pfa_dp (
   input  logic              clock,
   input  logic              reset,
   input  pfa_pkg::req_type  req_word,
   input  pfa_pkg::cmd_type  cmd,
   output pfa_pkg::stat_type stat,
   output logic              rsp_strobe,
   output pfa_pkg::rsp_type  rsp_word
);

   localparam int FW = pfa_pkg::FRAME_W;
   localparam int CW = pfa_pkg::COUNT_W;
   localparam int JW = pfa_pkg::JOB_W;

   // Captured request
   pfa_pkg::opcode_type op_ff, op_in;
   logic [JW-1:0]       job_ff, job_in;
   logic [CW-1:0]       size_ff, size_in;

   // Allocator state
   logic [FW-1:0]              head_ff, head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [pfa_pkg::MAX_JOBS-1:0] live_ff;
   logic [CW-1:0]              pages_ff [pfa_pkg::MAX_JOBS];
   logic [pfa_pkg::FRAMES-1:0] ring_valid_ff;

   // Walk counter and read stage
   logic [FW-1:0] k_ff, k_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   logic          rd_v_ff, rd_v_in;
   logic [FW-1:0] rd_k_ff, rd_k_in;
   logic          rd_last_ff, rd_last_in;
   logic          rd_hit_ff, rd_hit_in;
   logic [FW-1:0] rd_idx_ff, rd_idx_in;

   // Response register
   logic             rsp_strobe_ff, rsp_strobe_in;
   pfa_pkg::rsp_type rsp_word_ff, rsp_word_in;

   // Memory ports
   logic [FW-1:0]            ring_raddr, ring_waddr, ring_rdata, ring_wdata;
   logic                     ring_wen;
   logic [pfa_pkg::JF_AW-1:0] jf_raddr, jf_waddr;
   logic [FW-1:0]            jf_rdata, jf_wdata;
   logic                     jf_wen;

   logic          id_bad, k_last;
   logic [CW-1:0] n_pages;
   logic [FW-1:0] frame;

   pfa_ram #(.WIDTH(FW), .DEPTH(pfa_pkg::FRAMES)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wen),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   pfa_ram #(.WIDTH(FW), .DEPTH(pfa_pkg::JF_DEPTH)) u_jobframes (
      .clock   (clock),
      .wr_en   (jf_wen),
      .wr_addr (jf_waddr),
      .wr_data (jf_wdata),
      .rd_addr (jf_raddr),
      .rd_data (jf_rdata)
   );

   // Request checks
   assign id_bad  = 32'(job_ff) >= pfa_pkg::MAX_JOBS;
   assign n_pages = pages_ff[job_ff];
   assign k_last  = (CW'(k_ff) + CW'(1)) == tgt_ff;

   always_comb begin
      stat.id_bad    = id_bad;
      stat.live      = id_bad ? 1'b0 : live_ff[job_ff];
      stat.size_zero = (size_ff == '0);
      stat.size_gt   = (size_ff > count_ff);
      stat.op_free   = (op_ff == pfa_pkg::OP_FREE);
      stat.k_last    = k_last;
   end

   // Read side: ring at head+k, page table at (job, k)
   assign ring_raddr = pfa_pkg::ring_add(head_ff, CW'(k_ff));
   assign jf_raddr   = {job_ff, k_ff};

   // Ring entries never written read as their own index, their reset frame number
   assign frame = rd_hit_ff ? ring_rdata : rd_idx_ff;

   // Write side, in the cycle after the read
   assign jf_wen     = rd_v_ff && (op_ff == pfa_pkg::OP_ALLOC);
   assign jf_waddr   = {job_ff, rd_k_ff};
   assign jf_wdata   = frame;
   assign ring_wen   = rd_v_ff && (op_ff == pfa_pkg::OP_FREE);
   assign ring_waddr = pfa_pkg::ring_add(head_ff, CW'(rd_k_ff));
   assign ring_wdata = jf_rdata;

   // Next values
   always_comb begin
      op_in    = cmd.load ? req_word.opcode : op_ff;
      job_in   = cmd.load ? req_word.job_id : job_ff;
      size_in  = cmd.load ? req_word.request_size : size_ff;
      head_in  = head_ff;
      count_in = count_ff;
      k_in     = k_ff;
      tgt_in   = tgt_ff;

      if (cmd.alloc_start) begin
         count_in = count_ff - size_ff;
         tgt_in   = size_ff;
         k_in     = '0;
      end else if (cmd.free_start) begin
         // the freed frames go back in front of the current head
         head_in  = pfa_pkg::ring_add(head_ff, CW'(pfa_pkg::FRAMES) - n_pages);
         count_in = count_ff + n_pages;
         tgt_in   = n_pages;
         k_in     = '0;
      end else if (cmd.issue) begin
         k_in = k_ff + FW'(1);
         if (k_last && (op_ff == pfa_pkg::OP_ALLOC)) begin
            head_in = pfa_pkg::ring_add(head_ff, tgt_ff);
         end
      end

      rd_v_in    = cmd.issue;
      rd_k_in    = k_ff;
      rd_last_in = k_last;
      rd_hit_in  = ring_valid_ff[ring_raddr];
      rd_idx_in  = ring_raddr;
   end

   // Response word
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      if (cmd.err) begin
         rsp_strobe_in            = 1'b1;
         rsp_word_in.status       = cmd.err_code;
         rsp_word_in.page_number  = '0;
         rsp_word_in.frame_number = '0;
         rsp_word_in.free_frames  = count_ff;
         rsp_word_in.last         = 1'b1;
      end else if (cmd.done_free) begin
         rsp_strobe_in            = 1'b1;
         rsp_word_in.status       = pfa_pkg::ST_OK;
         rsp_word_in.page_number  = '0;
         rsp_word_in.frame_number = '0;
         rsp_word_in.free_frames  = count_ff;
         rsp_word_in.last         = 1'b1;
      end else if (jf_wen) begin
         rsp_strobe_in            = 1'b1;
         rsp_word_in.status       = pfa_pkg::ST_OK;
         rsp_word_in.page_number  = rd_k_ff;
         rsp_word_in.frame_number = frame;
         rsp_word_in.free_frames  = count_ff;
         rsp_word_in.last         = rd_last_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= CW'(pfa_pkg::FRAMES);
         live_ff       <= '0;
         ring_valid_ff <= '0;
         rd_v_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < pfa_pkg::MAX_JOBS; i++) begin
            pages_ff[i] <= '0;
         end
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         rd_v_ff       <= rd_v_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.alloc_start) begin
            live_ff[job_ff]  <= 1'b1;
            pages_ff[job_ff] <= size_ff;
         end else if (cmd.free_start) begin
            live_ff[job_ff]  <= 1'b0;
            pages_ff[job_ff] <= '0;
         end
         if (ring_wen) begin
            ring_valid_ff[ring_waddr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      job_ff      <= job_in;
      size_ff     <= size_in;
      k_ff        <= k_in;
      tgt_ff      <= tgt_in;
      rd_k_ff     <= rd_k_in;
      rd_last_ff  <= rd_last_in;
      rd_hit_ff   <= rd_hit_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef NO_ASSERTIONS
   // the free count never exceeds the pool
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pfa_pkg::FRAMES))
      else $error("free count above pool size");

   // pages of one allocation come out back to back
   a_pages_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_word_ff.last |=> rsp_strobe_ff)
      else $error("gap inside a page burst");

   // only successful allocations give more than one word
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_word_ff.last |-> rsp_word_ff.status == pfa_pkg::ST_OK)
      else $error("error word not marked last");
`endif

endmodule

// ===== rtl/paged_frame_allocator.sv =====
// Top level of the paged frame allocator: sequencer plus datapath.
//
// Takes a request word when start is high and busy is low, and answers with
// response words, each valid for exactly one cycle under rsp_strobe; the
// receiver cannot stall them. An allocate of N pages returns N words, one
// per cycle, page 0 first, last marked on page N-1. A free of a job
// holding N pages walks them and returns one word. A rejected request
// returns one error word. The walk over the N pages is set by the free
// ring and page-table RAMs, each moving one entry per cycle through its
// single read port; a new request can be taken as soon as busy is low.
// No clearing pass is needed after reset: per-entry valid bits give the
// ring its initial frame order.
module paged_frame_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pfa_pkg::req_type req_word,
   output logic             rsp_strobe,
   output pfa_pkg::rsp_type rsp_word
);

   pfa_pkg::cmd_type  cmd;
   pfa_pkg::stat_type stat;

   pfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pfa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== sim/tb_paged_frame_allocator.sv =====
// Self-checking testbench for the paged frame allocator: directed and random requests.
module tb_paged_frame_allocator;
   import pfa_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 260;
   localparam int DRAIN_CYCLES = 70;

   // Tracks free ring and page tables, and holds the response words still owed.
   class frame_ledger;
      logic [FRAME_W-1:0] free_ring [FRAMES];
      logic [FRAME_W-1:0] job_frames [MAX_JOBS][FRAMES];
      int                 job_pages [MAX_JOBS];
      bit                 job_live [MAX_JOBS];
      int                 ring_head;
      int                 free_count;
      rsp_type            owed_words [$];
      int                 errors;

      function new();
         for (int i = 0; i < FRAMES; i++) begin
            free_ring[i] = FRAME_W'(i);
         end
         for (int j = 0; j < MAX_JOBS; j++) begin
            job_pages[j] = 0;
            job_live[j]  = 1'b0;
         end
         ring_head  = 0;
         free_count = FRAMES;
         errors     = 0;
      endfunction

      function void owe_word(status_type st, int page, int frame, bit last);
         rsp_type w;
         w.status       = st;
         w.page_number  = FRAME_W'(page);
         w.frame_number = FRAME_W'(frame);
         w.free_frames  = COUNT_W'(free_count);
         w.last         = last;
         owed_words.push_back(w);
      endfunction

      // Apply one accepted request word to the ledger and queue its responses.
      function void take_request(req_type w);
         int job;
         int n;
         job = int'(w.job_id);
         n   = int'(w.request_size);
         if (job >= MAX_JOBS) begin
            owe_word(ST_UNKNOWN, 0, 0, 1'b1);
         end else if (w.opcode == OP_ALLOC) begin
            if (job_live[job] || n == 0) begin
               owe_word(ST_BUSY, 0, 0, 1'b1);
            end else if (n > free_count) begin
               owe_word(ST_NOFRAMES, 0, 0, 1'b1);
            end else begin
               // pop n frames from the front, page k gets the k-th one
               free_count -= n;
               for (int k = 0; k < n; k++) begin
                  job_frames[job][k] = free_ring[(ring_head + k) % FRAMES];
                  owe_word(ST_OK, k, int'(job_frames[job][k]), k == n - 1);
               end
               ring_head      = (ring_head + n) % FRAMES;
               job_pages[job] = n;
               job_live[job]  = 1'b1;
            end
         end else if (!job_live[job]) begin
            owe_word(ST_UNKNOWN, 0, 0, 1'b1);
         end else begin
            // push frames back so that page 0's frame is the new front
            n         = job_pages[job];
            ring_head = (ring_head + FRAMES - (n % FRAMES)) % FRAMES;
            for (int k = 0; k < n; k++) begin
               free_ring[(ring_head + k) % FRAMES] = job_frames[job][k];
            end
            free_count += n;
            if (free_count > FRAMES) begin
               free_count = FRAMES;
            end
            job_pages[job] = 0;
            job_live[job]  = 1'b0;
            owe_word(ST_OK, 0, 0, 1'b1);
         end
      endfunction

      function void check_field(string fname, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         end
      endfunction

      // Compare a response word against the oldest owed one.
      function void match_response(rsp_type got);
         rsp_type want;
         if (owed_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %p", $time, got);
         end else begin
            want = owed_words.pop_front();
            check_field("status", int'(want.status), int'(got.status));
            check_field("page_number", int'(want.page_number), int'(got.page_number));
            check_field("frame_number", int'(want.frame_number), int'(got.frame_number));
            check_field("free_frames", int'(want.free_frames), int'(got.free_frames));
            check_field("last", int'(want.last), int'(got.last));
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   frame_ledger ledger = new();
   int          cycle_count = 0;

   paged_frame_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response monitor: every strobed word is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         ledger.match_response(rsp_word);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type make_req(opcode_type op, int job, int size);
      req_type w;
      w.opcode       = op;
      w.job_id       = JOB_W'(job);
      w.request_size = COUNT_W'(size);
      return w;
   endfunction

   // Mostly well-formed traffic: free live jobs, allocate mostly small sizes.
   function automatic req_type pick_request();
      int r;
      int job;
      int size;
      r   = $urandom_range(99);
      job = $urandom_range(MAX_JOBS - 1);
      if (r < 8) begin
         return make_req(opcode_type'($urandom_range(1)), job, $urandom_range(127));
      end
      if (ledger.job_live[job] && r < 75) begin
         return make_req(OP_FREE, job, $urandom_range(127));
      end
      r = $urandom_range(99);
      if (r < 80) begin
         size = $urandom_range(8, 1);
      end else if (r < 95) begin
         size = $urandom_range(40, 9);
      end else begin
         size = $urandom_range(FRAMES, 41);
      end
      return make_req(OP_ALLOC, job, size);
   endfunction

   // Present one word, idling first at random, and return on the accepting edge.
   task automatic send_word(input req_type w, input bit may_idle);
      if (may_idle && $urandom_range(99) < 13) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.take_request(w);
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: rejects, full and empty list, frees out of allocation order
      send_word(make_req(OP_FREE, 0, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 0, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 0, 127), 1'b1);
      send_word(make_req(OP_ALLOC, 0, 65), 1'b1);
      send_word(make_req(OP_ALLOC, 1, 1), 1'b1);
      send_word(make_req(OP_ALLOC, 1, 3), 1'b1);
      send_word(make_req(OP_ALLOC, 2, 64), 1'b1);
      send_word(make_req(OP_ALLOC, 2, 63), 1'b1);
      send_word(make_req(OP_ALLOC, 3, 1), 1'b1);
      send_word(make_req(OP_FREE, 1, 127), 1'b1);
      send_word(make_req(OP_FREE, 2, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 15, 64), 1'b1);
      send_word(make_req(OP_FREE, 15, 0), 1'b1);
      send_word(make_req(OP_FREE, 15, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 4, 5), 1'b1);
      send_word(make_req(OP_ALLOC, 5, 7), 1'b1);
      send_word(make_req(OP_FREE, 4, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 6, 10), 1'b1);
      send_word(make_req(OP_FREE, 5, 0), 1'b1);
      send_word(make_req(OP_ALLOC, 7, 47), 1'b1);
      send_word(make_req(OP_FREE, 6, 0), 1'b1);
      send_word(make_req(OP_FREE, 7, 0), 1'b1);

      // Random traffic, with a stretch of back-to-back words in the middle
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         send_word(pick_request(), !(i >= 100 && i < 160));
      end
      start <= 1'b0;

      // Drain owed words, then watch for strays
      while (ledger.owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.errors == 0 && ledger.owed_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_ctrl.sv
rtl/pfa_dp.sv
rtl/paged_frame_allocator.sv
sim/tb_paged_frame_allocator.sv
